[hdl/pdpu_pkg.sv]
package pdpu_pkg;

	localparam int LANES = 4;
	localparam int OPW = 17;
	localparam int PRODW = 2 * OPW;
	localparam int SUMW = PRODW + 2;
	localparam int VALW = 33;

	localparam logic [SUMW-1:0] ROUND_TERM = SUMW'(32'h0000_8000);

	typedef enum logic [2:0] {
		ACT_SUM16      = 3'd0,
		ACT_SUM16_PAIR = 3'd1,
		ACT_DIFF16     = 3'd2,
		ACT_RDIFF_SU16 = 3'd3,
		ACT_RSUM_SU16  = 3'd4,
		ACT_SU8X4      = 3'd5,
		ACT_U8X4       = 3'd6,
		ACT_INVALID    = 3'd7
	} action_t;

	typedef struct packed {
		action_t     action;
		logic [31:0] first_source;
		logic [31:0] second_source;
	} cmd_t;

	typedef struct packed {
		logic signed [VALW-1:0] dot_value;
		logic                   undefined_flag;
		logic                   valid_flag;
	} res_t;

endpackage

[hdl/pdpu_lane.sv]
module pdpu_lane
	import pdpu_pkg::*;
(
	input  logic                    clk,
	input  logic signed [OPW-1:0]   op_a,
	input  logic signed [OPW-1:0]   op_b,
	output logic signed [PRODW-1:0] prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

endmodule

[hdl/pdpu_merge.sv]
module pdpu_merge
	import pdpu_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    vld_s1,
	input  action_t                 action_s1,
	input  logic signed [PRODW-1:0] prod_s1 [LANES],
	output logic                    done,
	output res_t                    result
);

	logic signed [SUMW-1:0] p0, p1, p2, p3;
	logic signed [SUMW-1:0] sum_all;
	logic signed [SUMW-1:0] diff_hi_lo;
	logic signed [SUMW-1:0] mid;
	logic                   mid_ok;
	res_t                   res_d;
	res_t                   result_q;
	logic                   done_q;

	always_comb begin
		p0 = SUMW'(prod_s1[0]);
		p1 = SUMW'(prod_s1[1]);
		p2 = SUMW'(prod_s1[2]);
		p3 = SUMW'(prod_s1[3]);
		// unused lanes carry zero products in halfword modes
		sum_all = p0 + p1 + p2 + p3;
		diff_hi_lo = p1 - p0;
		mid = ((action_s1 == ACT_RDIFF_SU16) ? diff_hi_lo : sum_all) + ROUND_TERM;
		// intermediate fits signed 32 bits when the top bits all match
		mid_ok = (mid[SUMW-1:31] == '0) || (mid[SUMW-1:31] == '1);
	end

	always_comb begin
		res_d.dot_value = '0;
		res_d.undefined_flag = 1'b0;
		res_d.valid_flag = 1'b1;
		case (action_s1)
			ACT_SUM16, ACT_SUM16_PAIR, ACT_SU8X4, ACT_U8X4: begin
				res_d.dot_value = sum_all[VALW-1:0];
			end
			ACT_DIFF16: begin
				res_d.dot_value = diff_hi_lo[VALW-1:0];
			end
			ACT_RDIFF_SU16, ACT_RSUM_SU16: begin
				if (mid_ok) begin
					res_d.dot_value = {{(VALW-(SUMW-16)){mid[SUMW-1]}}, mid[SUMW-1:16]};
				end else begin
					res_d.undefined_flag = 1'b1;
				end
			end
			default: begin
				res_d.valid_flag = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done = done_q;
	assign result = result_q;

endmodule

[hdl/packed_dot_product_unit.sv]
// Packed dot product unit.
//
// Command channel: drive cmd and raise start for one cycle; the command
// transfers at the rising edge where start is high and busy is low. busy is
// held low, so a new command may transfer in every cycle.
//
// Result channel: done pulses for exactly one cycle with result valid in
// that cycle. The receiver cannot stall; it must take the transfer then.
//
// A command reaches done through the stage registers; throughput is one
// item per cycle. Four multiplier lanes form the element products in the
// first stage (two lanes in halfword modes, all four in byte modes), and the
// merge stage adds, subtracts and rounds them in the second.
//
// Reset clears the pipeline valid bits; commands in flight are dropped and
// no done pulse appears until a new command transfers.
module packed_dot_product_unit
	import pdpu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t result
);

	logic signed [OPW-1:0]   op_a [LANES];
	logic signed [OPW-1:0]   op_b [LANES];
	logic signed [PRODW-1:0] prod_s1 [LANES];
	logic                    vld_s1;
	action_t                 action_s1;
	logic                    byte_mode;
	logic                    b_signed;
	logic                    a_byte_signed;

	assign busy = 1'b0;

	always_comb begin
		byte_mode = cmd.action inside {ACT_SU8X4, ACT_U8X4};
		b_signed = cmd.action inside {ACT_SUM16, ACT_SUM16_PAIR, ACT_DIFF16};
		a_byte_signed = (cmd.action == ACT_SU8X4);
		for (int i = 0; i < LANES; i++) begin
			if (byte_mode) begin
				op_a[i] = {{(OPW-8){a_byte_signed & cmd.first_source[8*i+7]}},
					cmd.first_source[8*i +: 8]};
				op_b[i] = {{(OPW-8){1'b0}}, cmd.second_source[8*i +: 8]};
			end else if (i < 2) begin
				op_a[i] = {cmd.first_source[16*i+15], cmd.first_source[16*i +: 16]};
				op_b[i] = {b_signed & cmd.second_source[16*i+15],
					cmd.second_source[16*i +: 16]};
			end else begin
				op_a[i] = '0;
				op_b[i] = '0;
			end
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		pdpu_lane u_lane (
			.clk     (clk),
			.op_a    (op_a[g]),
			.op_b    (op_b[g]),
			.prod_s1 (prod_s1[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		action_s1 <= cmd.action;
	end

	pdpu_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s1    (vld_s1),
		.action_s1 (action_s1),
		.prod_s1   (prod_s1),
		.done      (done),
		.result    (result)
	);

endmodule

[hdl/pdpu_checker.sv]
module pdpu_checker
	import pdpu_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input cmd_t cmd,
	input logic done,
	input res_t result
);

	// every transfer in yields a result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("command transfer not followed by result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a command transfer");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.valid_flag) |->
			(result.dot_value == '0 && !result.undefined_flag))
		else $error("invalid result not cleared");

	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.undefined_flag) |->
			(result.valid_flag && result.dot_value == '0))
		else $error("undefined result not zero");

	a_undef_rounded: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.undefined_flag) |->
			($past(cmd.action, 2) == ACT_RDIFF_SU16 ||
			 $past(cmd.action, 2) == ACT_RSUM_SU16))
		else $error("undefined flag on a form without rounding");

endmodule

bind packed_dot_product_unit pdpu_checker u_pdpu_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);
